@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

@@ rtl/deq_pkg.sv @@
package deq_pkg;

    // Default sizing
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // Command codes
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } deq_in_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               popped_valid;
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic               is_empty;
    } deq_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;     // capture the incoming transaction
        logic exec;     // apply the command to pointers and storage
        logic load;     // move the result into the output register
    } deq_ctrl_t;

endpackage

@@ rtl/deq_ctrl.sv @@
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output logic               res_valid,
    input  logic               res_ready,
    output deq_pkg::deq_ctrl_t ctrl
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    // Sequence one command: take, execute, deliver
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        ctrl           = '0;
        cmd_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.take  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                // Hold the result until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    ctrl.load      = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

@@ rtl/deq_datapath.sv @@
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_in_t   cmd,
    input  deq_pkg::deq_ctrl_t ctrl,
    output deq_pkg::deq_out_t  res
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [1:0]            cmd_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    deq_out_t              res_reg, res_next;

    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [IDX_W-1:0]      front_inc, front_dec, back_inc, back_dec;
    logic                  full, empty;

    // Ring neighbors of both pointers
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign back_inc  = (back_reg == IDX_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? IDX_W'(DEPTH - 1) : back_reg - 1'b1;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Apply the held command to pointers, count and storage
    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        pop_ok_next = pop_ok_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_reg;
        rd_addr     = front_reg;
        if (ctrl.exec)
        begin
            pop_ok_next = 1'b0;
            status_next = STAT_DONE;
            case (cmd_reg)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (cmd_reg == CMD_PUSH_FRONT)
                        begin
                            wr_addr    = front_dec;
                            front_next = front_dec;
                        end
                        else
                        begin
                            wr_addr   = back_reg;
                            back_next = back_inc;
                        end
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        pop_ok_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                        if (cmd_reg == CMD_POP_FRONT)
                        begin
                            rd_addr    = front_reg;
                            front_next = front_inc;
                        end
                        else
                        begin
                            rd_addr   = back_dec;
                            back_next = back_dec;
                        end
                    end
                end
            endcase
        end
    end

    // Build the result transaction
    always_comb
    begin
        res_next              = res_reg;
        if (ctrl.load)
        begin
            res_next.popped_value = pop_ok_reg ? 32'(rd_data_reg) : '0;
            res_next.popped_valid = pop_ok_reg;
            res_next.status       = status_reg;
            res_next.entry_count  = 5'(count_reg);
            res_next.is_empty     = (count_reg == '0);
        end
    end

    // Pointer and count state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            cmd_reg  <= cmd.command;
            word_reg <= DATA_WIDTH'($unsigned(cmd.value));
        end
        pop_ok_reg <= pop_ok_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    // Entry storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/double_ended_queue.sv @@
// Channel  | Handshake             | Payload
// command  | cmd_valid / cmd_ready | cmd (command, value)
// result   | res_valid / res_ready | res (popped_value, popped_valid, status, entry_count, is_empty)
//
// Each command passes through capture, execute, then the registered memory
// read lands and the result loads into the output register.
// A new command is taken once the previous result sits in the output register.
// A stalled result holds the read step until the output register frees up.
// Reset clears the pointers and count; entry storage is not cleared.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  deq_pkg::deq_in_t  cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output deq_pkg::deq_out_t res
);
    import deq_pkg::*;

    deq_ctrl_t ctrl;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ctrl      (ctrl)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctrl  (ctrl),
        .res   (res)
    );

endmodule

@@ rtl/deq_checker.sv @@
`include "assert_macros.svh"

module deq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input deq_pkg::deq_in_t  cmd,
    input logic              res_valid,
    input logic              res_ready,
    input deq_pkg::deq_out_t res
);
    import deq_pkg::*;

    // Empty flag tracks the count
    `ASSERT_IMPLY(a_empty_flag, res_valid, res.is_empty == (res.entry_count == 5'd0), "empty flag disagrees with count")

    // A refused pop leaves an empty ring and returns nothing
    `ASSERT_IMPLY(a_pop_empty, res_valid && res.status == STAT_EMPTY, res.entry_count == 5'd0 && !res.popped_valid, "empty status with entries or data")

    // Only a completed pop carries data
    `ASSERT_IMPLY(a_no_data, res_valid && !res.popped_valid, res.popped_value == 32'sd0, "data without a pop")

    // Stalled result holds
    `ASSERT_CLK(a_res_hold, $past(res_valid && !res_ready) |-> (res_valid && $stable(res)), "result changed while stalled")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
